FILE: hdl/pctp_pkg.sv
`timescale 1ns / 1ps

package pctp_pkg;

  localparam int WAYS       = 4;
  localparam int SETS       = 16;
  localparam int LINE_BYTES = 32;
  localparam int ADDR_BITS  = 32;

  localparam int WAY_W  = $clog2(WAYS);
  localparam int SET_W  = $clog2(SETS);
  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int TAG_W  = ADDR_BITS - SET_W - OFF_W;
  localparam int KIND_W = 3;
  localparam int LEN_W  = 6;
  localparam int ACT_W  = 2;
  localparam int SUM_W  = ((OFF_W > LEN_W) ? OFF_W : LEN_W) + 1;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_READ_WAY      = 2'd0,
    ACT_WRITE_CACHE   = 2'd1,
    ACT_WRITE_THROUGH = 2'd2,
    ACT_MEM_DIRECT    = 2'd3
  } action_e;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [KIND_W-1:0] kind;
    logic              dirty;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic resolve;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_blocked;
  } status_t;

endpackage

FILE: hdl/pctp_ctrl.sv
`timescale 1ns / 1ps

module pctp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pctp_pkg::status_t status_i,
  output pctp_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!status_i.out_blocked) begin
          cmd_o.resolve = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/pctp_dpath.sv
`timescale 1ns / 1ps

module pctp_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pctp_pkg::cmd_t                    cmd_i,
  output pctp_pkg::status_t                 status_o,
  input  logic                              command_i,
  input  logic [pctp_pkg::ADDR_BITS-1:0]    address_i,
  input  logic [pctp_pkg::KIND_W-1:0]       picture_kind_i,
  input  logic [pctp_pkg::LEN_W-1:0]        write_length_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic [pctp_pkg::WAY_W-1:0]        way_used_o,
  output logic [pctp_pkg::SET_W-1:0]        set_index_o,
  output logic                              writeback_needed_o,
  output logic [pctp_pkg::ADDR_BITS-1:0]    writeback_address_o,
  output logic                              fill_needed_o,
  output logic [pctp_pkg::ADDR_BITS-1:0]    fill_address_o,
  output logic [pctp_pkg::ACT_W-1:0]        data_action_o
);

  // captured transaction
  logic                              cmd_q;
  logic [pctp_pkg::ADDR_BITS-1:0]    addr_q;
  logic [pctp_pkg::KIND_W-1:0]       kind_q;
  logic [pctp_pkg::LEN_W-1:0]        len_q;

  // tag/flag row memory, valid bits in flops
  pctp_pkg::row_t                    tag_mem_q [pctp_pkg::SETS];
  pctp_pkg::row_t                    rd_row_q;
  logic [pctp_pkg::WAYS-1:0]         valid_q   [pctp_pkg::SETS];
  logic [pctp_pkg::WAY_W-1:0]        victim_ptr_q, victim_ptr_d;

  // output register
  logic                              out_valid_q;
  logic                              hit_q, wb_q, fill_q;
  logic [pctp_pkg::WAY_W-1:0]        way_q;
  logic [pctp_pkg::SET_W-1:0]        set_out_q;
  logic [pctp_pkg::ADDR_BITS-1:0]    wba_q, fa_q;
  logic [pctp_pkg::ACT_W-1:0]        act_q;

  // lookup logic
  logic [pctp_pkg::SET_W-1:0]        set_w;
  logic [pctp_pkg::TAG_W-1:0]        tag_w;
  logic [pctp_pkg::OFF_W-1:0]        off_w;
  logic [pctp_pkg::WAYS-1:0]         row_valid;
  pctp_pkg::row_t                    ent, new_row;
  logic                              found, any_empty, any_kind, reach, row_we;
  logic [pctp_pkg::WAY_W-1:0]        found_way, empty_way, kind_way, victim;
  logic [pctp_pkg::SUM_W-1:0]        end_pos;
  logic                              hit_d, wb_d, fill_d;
  logic [pctp_pkg::WAY_W-1:0]        way_d;
  logic [pctp_pkg::ADDR_BITS-1:0]    wba_d, fa_d;
  logic [pctp_pkg::ACT_W-1:0]        act_d;

  assign set_w     = addr_q[pctp_pkg::OFF_W +: pctp_pkg::SET_W];
  assign tag_w     = addr_q[pctp_pkg::ADDR_BITS-1 -: pctp_pkg::TAG_W];
  assign off_w     = addr_q[pctp_pkg::OFF_W-1:0];
  assign row_valid = valid_q[set_w];
  assign end_pos   = pctp_pkg::SUM_W'(off_w) + pctp_pkg::SUM_W'(len_q);
  assign reach     = end_pos >= pctp_pkg::SUM_W'(pctp_pkg::LINE_BYTES);

  always_comb begin
    found     = 1'b0;
    any_empty = 1'b0;
    any_kind  = 1'b0;
    found_way = '0;
    empty_way = '0;
    kind_way  = '0;
    for (int w = 0; w < pctp_pkg::WAYS; w++) begin
      ent[w] = row_valid[w] ? rd_row_q[w] : '0;
    end
    // lowest index wins
    for (int w = pctp_pkg::WAYS - 1; w >= 0; w--) begin
      if (row_valid[w] && (ent[w].tag == tag_w)) begin
        found     = 1'b1;
        found_way = pctp_pkg::WAY_W'(w);
      end
      if (!row_valid[w]) begin
        any_empty = 1'b1;
        empty_way = pctp_pkg::WAY_W'(w);
      end
      if (ent[w].kind == kind_q) begin
        any_kind = 1'b1;
        kind_way = pctp_pkg::WAY_W'(w);
      end
    end
  end

  always_comb begin
    victim_ptr_d = victim_ptr_q;
    if (any_empty) begin
      victim = empty_way;
    end else if (any_kind) begin
      victim = kind_way;
    end else begin
      victim = victim_ptr_q;
      if (victim_ptr_q == pctp_pkg::WAY_W'(pctp_pkg::WAYS - 1)) begin
        victim_ptr_d = '0;
      end else begin
        victim_ptr_d = victim_ptr_q + 1'b1;
      end
    end
  end

  always_comb begin
    hit_d   = 1'b0;
    way_d   = '0;
    wb_d    = 1'b0;
    wba_d   = '0;
    fill_d  = 1'b0;
    fa_d    = '0;
    act_d   = pctp_pkg::ACT_READ_WAY;
    new_row = ent;
    row_we  = 1'b0;
    if (cmd_q == pctp_pkg::CMD_READ) begin
      if (found) begin
        hit_d = 1'b1;
        way_d = found_way;
      end else begin
        way_d  = victim;
        row_we = 1'b1;
        if (row_valid[victim] && ent[victim].dirty) begin
          wb_d  = 1'b1;
          wba_d = {ent[victim].tag, set_w, {pctp_pkg::OFF_W{1'b0}}};
        end
        fill_d = 1'b1;
        fa_d   = {addr_q[pctp_pkg::ADDR_BITS-1:pctp_pkg::OFF_W], {pctp_pkg::OFF_W{1'b0}}};
        new_row[victim].tag   = tag_w;
        new_row[victim].kind  = kind_q;
        new_row[victim].dirty = 1'b0;
      end
    end else begin
      if (found) begin
        hit_d  = 1'b1;
        way_d  = found_way;
        row_we = 1'b1;
        new_row[found_way].dirty = !reach;
        act_d  = reach ? pctp_pkg::ACT_WRITE_THROUGH : pctp_pkg::ACT_WRITE_CACHE;
      end else begin
        act_d = pctp_pkg::ACT_MEM_DIRECT;
      end
    end
  end

  assign status_o.out_blocked = out_valid_q & out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= command_i;
      addr_q   <= address_i;
      kind_q   <= picture_kind_i;
      len_q    <= write_length_i;
      rd_row_q <= tag_mem_q[address_i[pctp_pkg::OFF_W +: pctp_pkg::SET_W]];
    end
    if (cmd_i.resolve && row_we) begin
      tag_mem_q[set_w] <= new_row;
    end
    if (cmd_i.resolve) begin
      hit_q     <= hit_d;
      way_q     <= way_d;
      set_out_q <= set_w;
      wb_q      <= wb_d;
      wba_q     <= wba_d;
      fill_q    <= fill_d;
      fa_q      <= fa_d;
      act_q     <= act_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < pctp_pkg::SETS; s++) begin
        valid_q[s] <= '0;
      end
      victim_ptr_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.resolve) begin
        out_valid_q <= 1'b1;
        if ((cmd_q == pctp_pkg::CMD_READ) && !found) begin
          valid_q[set_w][victim] <= 1'b1;
          victim_ptr_q           <= victim_ptr_d;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign hit_o               = hit_q;
  assign way_used_o          = way_q;
  assign set_index_o         = set_out_q;
  assign writeback_needed_o  = wb_q;
  assign writeback_address_o = wba_q;
  assign fill_needed_o       = fill_q;
  assign fill_address_o      = fa_q;
  assign data_action_o       = act_q;

endmodule

FILE: hdl/pixel_cache_tag_policy_core.sv
`timescale 1ns / 1ps
// An accepted input transaction is captured with its tag/flag row; its result enters
// the output register when the lookup resolves, which waits while a stalled earlier
// result is held. No transaction is taken during a lookup: the accept cycle
// reads the tag/flag row, the lookup cycle resolves it and writes the row back.
// Reset (async, active low) clears all valid marks, the victim pointer, the
// controller state and the output valid; tag, kind and dirty rows need no sweep.

module pixel_cache_tag_policy_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [pctp_pkg::ADDR_BITS-1:0]    address_i,
  input  logic [pctp_pkg::KIND_W-1:0]       picture_kind_i,
  input  logic [pctp_pkg::LEN_W-1:0]        write_length_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic [pctp_pkg::WAY_W-1:0]        way_used_o,
  output logic [pctp_pkg::SET_W-1:0]        set_index_o,
  output logic                              writeback_needed_o,
  output logic [pctp_pkg::ADDR_BITS-1:0]    writeback_address_o,
  output logic                              fill_needed_o,
  output logic [pctp_pkg::ADDR_BITS-1:0]    fill_address_o,
  output logic [pctp_pkg::ACT_W-1:0]        data_action_o
);

  pctp_pkg::cmd_t    cmd;
  pctp_pkg::status_t status;

  pctp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pctp_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .command_i           (command_i),
    .address_i           (address_i),
    .picture_kind_i      (picture_kind_i),
    .write_length_i      (write_length_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .hit_o               (hit_o),
    .way_used_o          (way_used_o),
    .set_index_o         (set_index_o),
    .writeback_needed_o  (writeback_needed_o),
    .writeback_address_o (writeback_address_o),
    .fill_needed_o       (fill_needed_o),
    .fill_address_o      (fill_address_o),
    .data_action_o       (data_action_o)
  );

endmodule

FILE: hdl/pctp_checker.sv
`timescale 1ns / 1ps

module pctp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              hit_o,
  input logic                              writeback_needed_o,
  input logic                              fill_needed_o,
  input logic [pctp_pkg::ACT_W-1:0]        data_action_o
);

  // a result waiting to be taken stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one transaction at a time: input closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken during lookup");

  // a new result only appears at the end of a lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a lookup");

  // fills come only from read misses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fill_needed_o |->
      !hit_o && (data_action_o == pctp_pkg::ACT_READ_WAY))
    else $error("fill on a hit or a write");

  // write-back only alongside a fill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && writeback_needed_o |-> fill_needed_o)
    else $error("write-back without fill");

endmodule

bind pixel_cache_tag_policy_core pctp_checker u_pctp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .hit_o              (hit_o),
  .writeback_needed_o (writeback_needed_o),
  .fill_needed_o      (fill_needed_o),
  .data_action_o      (data_action_o)
);
